/* rtl/core/tolerant_point_dedup_table_macros.svh */
// Assertion helpers for the RTL files; tpdt_ctrl includes them.
`ifndef TOLERANT_POINT_DEDUP_TABLE_MACROS_SVH
`define TOLERANT_POINT_DEDUP_TABLE_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define TPDT_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define TPDT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define TPDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/tpdt_pkg.sv */
package tpdt_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_W    = 32;
    localparam int TOL_W      = 32;
    localparam int OUT_IDX_W  = 10;
    localparam int AXIS_LIMIT = 65536;
    localparam int AXIS_W     = $clog2(AXIS_LIMIT) + 1;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_W       = 2 * AXIS_W;
    localparam int SUM_W      = SQ_W + 2;

    localparam logic [TOL_W-1:0] TOL_RESET = 32'd281;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             last;
    } tag_t;

    typedef struct packed {
        logic valid;
        tag_t tag;
    } issue_t;

    typedef struct packed {
        logic valid;
        logic match;
        tag_t tag;
    } cmp_res_t;

    // Magnitude of a - s, exact in one extra bit.
    function automatic logic [DIFF_W-1:0] axis_abs(input logic signed [COORD_W-1:0] a,
                                                   input logic signed [COORD_W-1:0] s);
        logic signed [DIFF_W-1:0] d;
        d = DIFF_W'(a) - DIFF_W'(s);
        return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

endpackage

/* rtl/core/tpdt_point_if.sv */
interface tpdt_point_if import tpdt_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic signed [COORD_W-1:0] z_coord;

    modport source (output valid, output x_coord, output y_coord, output z_coord,
                    input ready);
    modport sink (input valid, input x_coord, input y_coord, input z_coord,
                  output ready);
endinterface

/* rtl/core/tpdt_result_if.sv */
interface tpdt_result_if import tpdt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OUT_IDX_W-1:0] vertex_index;
    logic                 was_new;
    logic                 table_full;

    modport source (output valid, output vertex_index, output was_new, output table_full,
                    input ready);
    modport sink (input valid, input vertex_index, input was_new, input table_full,
                  output ready);
endinterface

/* rtl/core/tpdt_cfg_if.sv */
interface tpdt_cfg_if import tpdt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [TOL_W-1:0] tolerance_squared;

    modport source (output valid, output tolerance_squared, input ready);
    modport sink (input valid, input tolerance_squared, output ready);
endinterface

/* rtl/core/tolerant_point_dedup_table.sv */
// An item is answered after a full scan of the stored points, or sooner on an early match;
// on an empty table it goes straight from IDLE to FINISH without a scan. A new point is
// taken only in IDLE, once the last decision has gone to the output register; the linear
// scan reads one stored point per cycle from the single point memory read port.
// Reset clears the point count, the tolerance (to 281) and all handshake state; the
// point memory is not cleared, entries at or above the count are never used.
module tolerant_point_dedup_table import tpdt_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    tpdt_cfg_if.sink      cfg,
    tpdt_point_if.sink    point,
    tpdt_result_if.source result
);

    logic [TOL_W-1:0] tol_reg;
    logic [TOL_W-1:0] tol_next;
    issue_t           issue;
    logic             flush;
    point_t           query;
    point_t           stored;
    cmp_res_t         res;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    point_t           wr_data;

    assign cfg.ready = 1'b1;
    assign tol_next  = cfg.valid ? cfg.tolerance_squared : tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else
        begin
            tol_reg <= tol_next;
        end
    end

    tpdt_ram #(
        .WIDTH ($bits(point_t)),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (issue.tag.index),
        .rdata (stored)
    );

    tpdt_cmp u_cmp (
        .clk    (clk),
        .rst_n  (rst_n),
        .issue  (issue),
        .flush  (flush),
        .query  (query),
        .stored (stored),
        .tol    (tol_reg),
        .res    (res)
    );

    tpdt_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .point   (point),
        .result  (result),
        .issue   (issue),
        .flush   (flush),
        .query   (query),
        .res     (res),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule

/* rtl/core/tpdt_ram.sv */
module tpdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/tpdt_cmp.sv */
module tpdt_cmp import tpdt_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  issue_t           issue,
    input  logic             flush,
    input  point_t           query,
    input  point_t           stored,
    input  logic [TOL_W-1:0] tol,
    output cmp_res_t         res
);

    // Stage 0 lines up the tag with the registered memory read.
    logic              s0_valid_reg;
    tag_t              s0_tag_reg;
    // Stage 1: axis magnitudes and the out-of-range flag.
    logic              s1_valid_reg;
    tag_t              s1_tag_reg;
    logic              s1_far_reg;
    logic              s1_far_next;
    logic [AXIS_W-1:0] s1_abs_reg  [3];
    logic [AXIS_W-1:0] s1_abs_next [3];
    // Stage 2: squares.
    logic              s2_valid_reg;
    tag_t              s2_tag_reg;
    logic              s2_far_reg;
    logic [SQ_W-1:0]   s2_sq_reg [3];
    // Stage 3: sum and compare.
    logic              res_valid_reg;
    logic              res_match_reg;
    logic              res_match_next;
    tag_t              res_tag_reg;

    logic signed [COORD_W-1:0] q_axis [3];
    logic signed [COORD_W-1:0] s_axis [3];
    logic [DIFF_W-1:0]         abs_full [3];
    logic [SUM_W-1:0]          sum;

    assign q_axis[0] = query.x;
    assign q_axis[1] = query.y;
    assign q_axis[2] = query.z;
    assign s_axis[0] = stored.x;
    assign s_axis[1] = stored.y;
    assign s_axis[2] = stored.z;

    always_comb
    begin
        s1_far_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            abs_full[i]    = axis_abs(q_axis[i], s_axis[i]);
            s1_abs_next[i] = abs_full[i][AXIS_W-1:0];
            if (abs_full[i] > DIFF_W'(AXIS_LIMIT))
            begin
                s1_far_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        sum = SUM_W'(s2_sq_reg[0]) + SUM_W'(s2_sq_reg[1]) + SUM_W'(s2_sq_reg[2]);
        res_match_next = !s2_far_reg && (sum < SUM_W'(tol));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (flush)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg  <= issue.valid;
            s1_valid_reg  <= s0_valid_reg;
            s2_valid_reg  <= s1_valid_reg;
            res_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_tag_reg    <= issue.tag;
        s1_tag_reg    <= s0_tag_reg;
        s1_far_reg    <= s1_far_next;
        s2_tag_reg    <= s1_tag_reg;
        s2_far_reg    <= s1_far_reg;
        res_tag_reg   <= s2_tag_reg;
        res_match_reg <= res_match_next;
        for (int i = 0; i < 3; i++)
        begin
            s1_abs_reg[i] <= s1_abs_next[i];
            s2_sq_reg[i]  <= SQ_W'(s1_abs_reg[i] * s1_abs_reg[i]);
        end
    end

    assign res.valid = res_valid_reg;
    assign res.match = res_match_reg;
    assign res.tag   = res_tag_reg;

endmodule

/* rtl/core/tpdt_ctrl.sv */
`include "tolerant_point_dedup_table_macros.svh"

module tpdt_ctrl import tpdt_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    tpdt_point_if.sink       point,
    tpdt_result_if.source    result,
    output issue_t           issue,
    output logic             flush,
    output point_t           query,
    input  cmp_res_t         res,
    output logic             wr_en,
    output logic [IDX_W-1:0] wr_addr,
    output point_t           wr_data
);

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        FINISH
    } state_t;

    state_t               state_reg,     state_next;
    logic [CNT_W-1:0]     count_reg,     count_next;
    logic [CNT_W-1:0]     iss_reg,       iss_next;
    point_t               query_reg,     query_next;
    logic                 hit_reg,       hit_next;
    logic [IDX_W-1:0]     hit_idx_reg,   hit_idx_next;
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_IDX_W-1:0] out_idx_reg,   out_idx_next;
    logic                 out_new_reg,   out_new_next;
    logic                 out_full_reg,  out_full_next;
    logic                 load_out;
    logic                 is_full;

    assign is_full  = (count_reg == CNT_W'(MAX_POINTS));
    assign load_out = !out_valid_reg || result.ready;

    assign issue.valid     = (state_reg == SCAN) && (iss_reg != count_reg);
    assign issue.tag.index = iss_reg[IDX_W-1:0];
    assign issue.tag.last  = ((iss_reg + CNT_W'(1)) == count_reg);

    // Clear stale compares left in flight after a decision.
    assign flush   = (state_reg == FINISH);
    assign query   = query_reg;
    assign wr_addr = count_reg[IDX_W-1:0];
    assign wr_data = query_reg;

    assign point.ready         = (state_reg == IDLE);
    assign result.valid        = out_valid_reg;
    assign result.vertex_index = out_idx_reg;
    assign result.was_new      = out_new_reg;
    assign result.table_full   = out_full_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        iss_next       = iss_reg;
        query_next     = query_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        out_valid_next = out_valid_reg;
        out_idx_next   = out_idx_reg;
        out_new_next   = out_new_reg;
        out_full_next  = out_full_reg;
        wr_en          = 1'b0;

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            IDLE:
            begin
                if (point.valid)
                begin
                    query_next.x = point.x_coord;
                    query_next.y = point.y_coord;
                    query_next.z = point.z_coord;
                    iss_next     = '0;
                    hit_next     = 1'b0;
                    if (count_reg == '0)
                    begin
                        state_next = FINISH;
                    end
                    else
                    begin
                        state_next = SCAN;
                    end
                end
            end
            SCAN:
            begin
                if (issue.valid)
                begin
                    iss_next = iss_reg + CNT_W'(1);
                end
                if (res.valid && res.match)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = res.tag.index;
                    state_next   = FINISH;
                end
                else if (res.valid && res.tag.last)
                begin
                    hit_next   = 1'b0;
                    state_next = FINISH;
                end
            end
            FINISH:
            begin
                // Hold the decision until the output register is free.
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = IDLE;
                    if (hit_reg)
                    begin
                        out_idx_next  = OUT_IDX_W'(hit_idx_reg);
                        out_new_next  = 1'b0;
                        out_full_next = 1'b0;
                    end
                    else if (is_full)
                    begin
                        out_idx_next  = '0;
                        out_new_next  = 1'b0;
                        out_full_next = 1'b1;
                    end
                    else
                    begin
                        wr_en         = 1'b1;
                        out_idx_next  = OUT_IDX_W'(count_reg);
                        out_new_next  = 1'b1;
                        out_full_next = 1'b0;
                        count_next    = count_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            count_reg     <= '0;
            iss_reg       <= '0;
            query_reg     <= '0;
            hit_reg       <= 1'b0;
            hit_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_idx_reg   <= '0;
            out_new_reg   <= 1'b0;
            out_full_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            iss_reg       <= iss_next;
            query_reg     <= query_next;
            hit_reg       <= hit_next;
            hit_idx_reg   <= hit_idx_next;
            out_valid_reg <= out_valid_next;
            out_idx_reg   <= out_idx_next;
            out_new_reg   <= out_new_next;
            out_full_reg  <= out_full_next;
        end
    end

    `TPDT_ASSERT_ALWAYS(a_count_max, clk, rst_n, count_reg <= CNT_W'(MAX_POINTS), "count above table size")
    `TPDT_ASSERT_IMP(a_issue_scan, clk, rst_n, issue.valid, state_reg == SCAN, "read issued outside scan")
    `TPDT_ASSERT_IMP(a_issue_range, clk, rst_n, issue.valid, iss_reg < count_reg, "read past stored points")
    `TPDT_ASSERT_IMP(a_wr_room, clk, rst_n, wr_en, !is_full, "write into full table")
    `TPDT_ASSERT_NEXT(a_wr_count, clk, rst_n, wr_en, count_reg == CNT_W'($past(count_reg) + CNT_W'(1)), "count not advanced on append")

endmodule

/* test/tb_tolerant_point_dedup_table.sv */
module tb_tolerant_point_dedup_table import tpdt_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_DIRECTED       = 24;
    localparam int N_PHASES         = 6;
    localparam int ITEMS_PER_PHASE  = 93;
    localparam int QUIET_LIMIT      = 20000;
    localparam int REPORT_LIMIT     = 10;
    localparam int COORD_MAX        = 32'sh7FFF_FFFF;
    localparam int COORD_MIN        = 32'sh8000_0000;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] vertex_index;
        logic                 was_new;
        logic                 table_full;
    } dedup_result_t;

    typedef enum logic {
        ROW_POINT,
        ROW_TOL
    } row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        point_t           pt;
        logic [TOL_W-1:0] tol;
        logic             typed;
        dedup_result_t    want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    tpdt_cfg_if    cfg_ch ();
    tpdt_point_if  point_ch ();
    tpdt_result_if result_ch ();

    tolerant_point_dedup_table i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .point  (point_ch),
        .result (result_ch)
    );

    // Shadow of the point table and the squared merge tolerance
    point_t           known_pts [MAX_POINTS];
    int unsigned      known_count;
    logic [TOL_W-1:0] merge_tol;

    dedup_result_t    pending_results [$];
    int               fail_count = 0;
    int               idle_pct;
    int               quiet_cycles = 0;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Scan in insertion order; first point within tolerance wins, else append, or report full.
    function automatic dedup_result_t merge_or_append(point_t p);
        dedup_result_t             r;
        logic signed [COORD_W-1:0] in_ax [3];
        logic signed [COORD_W-1:0] st_ax [3];
        longint                    d;
        longint                    dist_sq;
        bit                        near;
        in_ax = '{p.x, p.y, p.z};
        for (int i = 0; i < int'(known_count); i++)
        begin
            st_ax   = '{known_pts[i].x, known_pts[i].y, known_pts[i].z};
            dist_sq = 0;
            near    = 1'b1;
            for (int a = 0; a < 3; a++)
            begin
                d = longint'(in_ax[a]) - longint'(st_ax[a]);
                if (d < 0)
                    d = -d;
                if (d > AXIS_LIMIT)
                    near = 1'b0;
                else
                    dist_sq += d * d;
            end
            if (near && dist_sq < longint'(merge_tol))
            begin
                r.vertex_index = OUT_IDX_W'(i);
                r.was_new      = 1'b0;
                r.table_full   = 1'b0;
                return r;
            end
        end
        if (known_count >= MAX_POINTS)
        begin
            r.vertex_index = '0;
            r.was_new      = 1'b0;
            r.table_full   = 1'b1;
            return r;
        end
        known_pts[known_count] = p;
        r.vertex_index = OUT_IDX_W'(known_count);
        r.was_new      = 1'b1;
        r.table_full   = 1'b0;
        known_count++;
        return r;
    endfunction

    function automatic stim_row_t checked_row(int x, int y, int z);
        stim_row_t row;
        row       = '0;
        row.kind  = ROW_POINT;
        row.pt    = '{x, y, z};
        row.typed = 1'b0;
        return row;
    endfunction

    function automatic stim_row_t known_row(int x, int y, int z, int idx, bit is_new, bit full);
        stim_row_t row;
        row       = checked_row(x, y, z);
        row.typed = 1'b1;
        row.want  = '{OUT_IDX_W'(idx), is_new, full};
        return row;
    endfunction

    function automatic stim_row_t tol_row(logic [TOL_W-1:0] v);
        stim_row_t row;
        row      = '0;
        row.kind = ROW_TOL;
        row.tol  = v;
        return row;
    endfunction

    // Move a coordinate: mostly a little, sometimes across the axis limit, sometimes anywhere.
    function automatic logic [COORD_W-1:0] nudge(logic [COORD_W-1:0] c);
        int unsigned pick;
        int unsigned off;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return c + COORD_W'(int'($urandom_range(0, 40)) - 20);
        if (pick < 7)
            return c + COORD_W'(int'($urandom_range(0, 600)) - 300);
        if (pick == 9)
            return $urandom;
        off = (pick == 7) ? $urandom_range(65530, 65542) : $urandom_range(0, 1 << 20);
        return $urandom_range(0, 1) ? c + off : c - off;
    endfunction

    function automatic point_t random_point();
        point_t      p;
        point_t      base;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (known_count != 0 && pick < 70)
        begin
            base = known_pts[$urandom_range(0, known_count - 1)];
            p.x  = nudge(base.x);
            p.y  = nudge(base.y);
            p.z  = nudge(base.z);
        end
        else if (pick < 85)
        begin
            p.x = COORD_W'(int'($urandom_range(0, 1023)) - 512);
            p.y = COORD_W'(int'($urandom_range(0, 1023)) - 512);
            p.z = COORD_W'(int'($urandom_range(0, 1023)) - 512);
        end
        else
        begin
            p.x = $urandom;
            p.y = $urandom;
            p.z = $urandom;
        end
        return p;
    endfunction

    // Offer one point; hold valid across back-to-back items, drop it only to idle.
    task automatic send_point(input point_t p, input bit typed, input dedup_result_t want);
        dedup_result_t predicted;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            point_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct);
        end
        point_ch.valid   <= 1'b1;
        point_ch.x_coord <= p.x;
        point_ch.y_coord <= p.y;
        point_ch.z_coord <= p.z;
        do
            @(posedge clk);
        while (!point_ch.ready);
        predicted = merge_or_append(p);
        pending_results = {pending_results, (typed ? want : predicted)};
    endtask

    task automatic set_tolerance(input logic [TOL_W-1:0] v);
        point_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        cfg_ch.valid             <= 1'b1;
        cfg_ch.tolerance_squared <= v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        merge_tol = v;
    endtask

    always @(posedge clk)
    begin
        result_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
    end

    always @(posedge clk)
    begin : check_results
        dedup_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected item: index %0d new %0b full %0b",
                             result_ch.vertex_index, result_ch.was_new, result_ch.table_full);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_ch.vertex_index !== want.vertex_index ||
                    result_ch.was_new !== want.was_new ||
                    result_ch.table_full !== want.table_full)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("mismatch: expected index %0d new %0b full %0b, got %0d %0b %0b",
                                 want.vertex_index, want.was_new, want.table_full,
                                 result_ch.vertex_index, result_ch.was_new,
                                 result_ch.table_full);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (point_ch.valid && point_ch.ready) ||
            (result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        stim_row_t        directed_rows [N_DIRECTED];
        logic [TOL_W-1:0] phase_tols [N_PHASES];
        dedup_result_t    no_result;

        no_result    = '0;
        idle_pct     = 15;
        known_count  = 0;
        merge_tol    = TOL_RESET;

        rst_n                    <= 1'b0;
        point_ch.valid           <= 1'b0;
        point_ch.x_coord         <= '0;
        point_ch.y_coord         <= '0;
        point_ch.z_coord         <= '0;
        cfg_ch.valid             <= 1'b0;
        cfg_ch.tolerance_squared <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        directed_rows = '{
            known_row(0, 0, 0, 0, 1'b1, 1'b0),
            known_row(0, 0, 0, 0, 1'b0, 1'b0),
            checked_row(16, 0, 0),
            checked_row(0, 0, 17),
            known_row(COORD_MAX, COORD_MAX, COORD_MAX, 2, 1'b1, 1'b0),
            known_row(COORD_MIN, COORD_MIN, COORD_MIN, 3, 1'b1, 1'b0),
            known_row(COORD_MAX, COORD_MAX, COORD_MAX, 2, 1'b0, 1'b0),
            checked_row(-10, -10, -10),
            checked_row(COORD_MAX, COORD_MIN, 32'sh5555_5555),
            checked_row(32'shAAAA_AAAA, 32'sh5555_5555, COORD_MIN),
            tol_row(32'hFFFF_FFFF),
            checked_row(65535, 0, 0),
            checked_row(65536, 0, 0),
            checked_row(131073, 0, 0),
            // far away in the high bits, close in the low ones
            checked_row(32'sh4000_0005, 0, 0),
            checked_row(COORD_MIN + 3, COORD_MIN, COORD_MIN + 4),
            checked_row(0, 65536, 65536),
            checked_row(COORD_MAX, COORD_MAX - 65535, COORD_MAX),
            tol_row(32'd0),
            checked_row(0, 0, 0),
            checked_row(0, 0, 0),
            tol_row(32'd1),
            known_row(0, 0, 0, 0, 1'b0, 1'b0),
            checked_row(1, 0, 0)
        };

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_TOL)
                set_tolerance(directed_rows[i].tol);
            else
                send_point(directed_rows[i].pt, directed_rows[i].typed, directed_rows[i].want);
        end

        phase_tols = '{TOL_RESET, 32'hFFFF_FFFF, TOL_W'($urandom_range(0, 2000)),
                       $urandom, 32'd1, 32'd4_000_000};
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            set_tolerance(phase_tols[ph]);
            // one phase runs without any idling on either side
            idle_pct = (ph == 2) ? 0 : 15;
            repeat (ITEMS_PER_PHASE) send_point(random_point(), 1'b0, no_result);
        end

        point_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (MAX_POINTS + 16) @(posedge clk);

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/tpdt_pkg.sv
rtl/core/tpdt_point_if.sv
rtl/core/tpdt_result_if.sv
rtl/core/tpdt_cfg_if.sv
rtl/core/tpdt_ram.sv
rtl/core/tpdt_cmp.sv
rtl/core/tpdt_ctrl.sv
rtl/core/tolerant_point_dedup_table.sv
test/tb_tolerant_point_dedup_table.sv
